>>> rtl/cpfm_pkg.sv
`default_nettype none

package cpfm_pkg;

	// Width of the free-running capture timer.
	localparam int CounterBits = 16;

	localparam int HzBits  = 32;
	localparam int DivBits = 17;
	localparam int QuoBits = 32;
	localparam int CntBits = $clog2(QuoBits);

	localparam logic [HzBits-1:0]  ClockHzReset  = 32'd2000000;
	localparam logic [DivBits-1:0] ClockDivReset = 17'd31;

	// Operation codes carried in tuser.
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_CLOCK_HZ  = 1'b0;
	localparam logic CFG_CLOCK_DIV = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RATE,
		ST_FREQ
	} state_t;

	// Handshake between the sequencer and the serial divider.
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/cpfm_divider.sv
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module cpfm_divider
	import cpfm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire div_req_t           req,
	input  wire logic [QuoBits-1:0] dividend,
	input  wire logic [DivBits-1:0] divisor,
	output div_rsp_t                rsp,
	output logic      [QuoBits-1:0] quotient
);

	logic [QuoBits-1:0] quo_q;
	logic [DivBits-1:0] rem_q;
	logic [DivBits-1:0] dsr_q;
	logic [CntBits-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DivBits:0]   trial;
	logic [DivBits+1:0] diff;
	logic               fits;

	// The partial remainder stays below the divisor, so the shifted trial value
	// needs one bit more than the divisor and the difference one more for the borrow.
	assign trial = {rem_q, quo_q[QuoBits-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};
	assign fits  = !diff[DivBits+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntBits'(QuoBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QuoBits-2:0], fits};
			rem_q <= fits ? diff[DivBits-1:0] : trial[DivBits-1:0];
		end
	end

	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/capture_period_frequency_meter.sv
// A read returns its transfer on the output in the cycle after it is accepted.
// A capture that completes a pair closes the input while the bit-serial divider runs twice
// (tick rate, then frequency); other captures leave the input open.
// Throughput: one item at a time; the input stays stalled while a division runs.
// Reset (arst_n low, asynchronous): no pair pending, frequency zero, output empty,
// clock_hz = 2000000, clock_divisor = 31.
`default_nettype none

module capture_period_frequency_meter
	import cpfm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] capture_value
	input  wire logic        s_axis_tuser,   // [0] operation
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata    // [31:0] frequency_hz
);

	// Configuration registers.
	logic [HzBits-1:0]  clock_hz_q;
	logic [DivBits-1:0] clock_div_q;

	// Measurement state.
	logic                   awaiting_q;
	logic [CounterBits-1:0] first_q;
	logic [CounterBits-1:0] elapsed_q;
	logic [QuoBits-1:0]     freq_q;

	// Output register.
	logic               out_valid_q;
	logic [QuoBits-1:0] out_data_q;

	state_t state_q, state_d;

	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [QuoBits-1:0] div_dividend;
	logic [DivBits-1:0] div_divisor;
	logic [QuoBits-1:0] div_quotient;

	logic                   in_xfer;
	logic                   is_read;
	logic [CounterBits-1:0] cap;
	logic                   pair_done;
	logic [DivBits-1:0]     eff_div;

	assign cap     = s_axis_tdata[CounterBits-1:0];
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign is_read = (s_axis_tuser == OP_READ);

	// A second capture that differs from the first closes the pair and starts the math.
	assign pair_done = in_xfer && !is_read && awaiting_q && (cap != first_q);

	// A divisor of zero is taken as one.
	assign eff_div = (clock_div_q == '0) ? DivBits'(1) : clock_div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= ClockHzReset;
			clock_div_q <= ClockDivReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLOCK_HZ:  clock_hz_q  <= cfg_data;
				CFG_CLOCK_DIV: clock_div_q <= cfg_data[DivBits-1:0];
				default:       ;
			endcase
		end
	end

	// Next-state logic: idle, then tick rate = clock_hz / divisor, then
	// frequency = tick rate / elapsed ticks.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (pair_done) state_d = ST_RATE;
			ST_RATE: if (div_rsp.done) state_d = ST_FREQ;
			ST_FREQ: if (div_rsp.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Output logic: the input is open only when idle and the output register
	// is free or being emptied in this cycle.
	always_comb begin
		s_axis_tready = 1'b0;
		div_req.start = 1'b0;
		div_dividend  = clock_hz_q;
		div_divisor   = eff_div;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = !out_valid_q || m_axis_tready;
				div_req.start = pair_done;
			end
			ST_RATE: begin
				div_req.start = div_rsp.done;
				div_dividend  = div_quotient;
				div_divisor   = {{(DivBits - CounterBits){1'b0}}, elapsed_q};
			end
			ST_FREQ: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			awaiting_q  <= 1'b0;
			first_q     <= '0;
			freq_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new read refills the output register; otherwise a taken result empties it.
			if (in_xfer && is_read) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				if (is_read) begin
					// A read hands out the stored value and clears it.
					freq_q <= '0;
				end else if (!awaiting_q) begin
					first_q    <= cap;
					awaiting_q <= 1'b1;
				end
				// Equal captures leave the first one in place and keep waiting.
			end
			if (state_q == ST_FREQ && div_rsp.done) begin
				freq_q     <= div_quotient;
				awaiting_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && is_read) begin
			out_data_q <= freq_q;
		end
		// The subtraction wraps at the counter width, which covers a rolled-over timer.
		if (pair_done) begin
			elapsed_q <= cap - first_q;
		end
	end

	cpfm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rsp      (div_rsp),
		.quotient (div_quotient)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/cpfm_checker.sv
`default_nettype none

module cpfm_checker
	import cpfm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	logic rd_xfer;
	logic cap_xfer;

	assign rd_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_READ);
	assign cap_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CAPTURE);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer dropped or changed while stalled");

	// Every accepted read produces a result in the next cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_xfer |=> m_axis_tvalid)
		else $error("read did not produce a result");

	// Two reads in a row: the second one sees the cleared frequency.
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rd_xfer ##1 rd_xfer |=> m_axis_tdata == 32'd0)
		else $error("read did not clear the stored frequency");

	// A capture accepted while the output is empty never produces a result.
	a_capture_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cap_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("capture produced a result");

endmodule

bind capture_period_frequency_meter cpfm_checker u_cpfm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
